### rtl/qpd_pkg.sv
// ----------------------------------------------------------------------------
// qpd_pkg
// Shared types, constants and helpers of the quoted-printable decoder.
// ----------------------------------------------------------------------------
package qpd_pkg;

    localparam int unsigned QPD_FIFO_DEPTH = 4;
    localparam int unsigned QPD_MAX_RES    = 5;

    localparam logic [7:0] CHAR_EQ = 8'h3D;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] REPL_HI = 8'hFF;
    localparam logic [7:0] REPL_LO = 8'hFD;

    typedef enum logic [1:0] {
        MODE_FAIL    = 2'd0,
        MODE_REPLACE = 2'd1,
        MODE_IGNORE  = 2'd2
    } t_err_mode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ERR  = 2'd1,
        ST_FAIL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_PLAIN = 3'b001,
        PH_EQ    = 3'b010,
        PH_HELD  = 3'b100
    } t_phase;

    // One classified input item: up to five decoded bytes plus message end info.
    typedef struct packed {
        logic [QPD_MAX_RES-1:0][7:0] data;
        logic [2:0]                  cnt;
        logic                        last;
        t_status                     status;
    } t_item;

    // Returns {ok, nibble}.
    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    function automatic t_item push(t_item it, logic [7:0] b);
        t_item r;
        r = it;
        r.data[r.cnt] = b;
        r.cnt = 3'(r.cnt + 3'd1);
        return r;
    endfunction

    // Replacement bytes of a handled bad escape (nothing in ignore mode).
    function automatic t_item bad_push(t_item it, t_err_mode m);
        t_item r;
        r = it;
        if (m == MODE_REPLACE) begin
            r = push(r, REPL_HI);
            r = push(r, REPL_LO);
        end
        return r;
    endfunction

endpackage

### rtl/qpd_front.sv
// ----------------------------------------------------------------------------
// qpd_front
// Accepts encoded bytes, tracks the escape state and turns each byte that
// causes decoded bytes or ends a message into one queue item holding them.
// ----------------------------------------------------------------------------
module qpd_front import qpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_item      o_q_item
);

    t_err_mode r_mode;
    t_phase    r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       r_err, n_err;
    logic       r_fail, n_fail;
    logic       accept;
    logic       is_fail;
    logic [4:0] hx_h, hx_b;
    t_item      it;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_q_full;
    assign accept      = i_in_valid && !i_q_full;
    assign is_fail     = (r_mode == MODE_FAIL);
    assign hx_h        = hex_val(r_held);
    assign hx_b        = hex_val(i_in_byte);

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_err   = r_err;
        n_fail  = r_fail;
        it      = '0;
        it.last = i_in_last;
        if (!r_fail) begin
            unique case (r_phase)
                PH_EQ: begin
                    if (i_in_last) begin
                        n_phase = PH_PLAIN;
                        if (is_fail) begin
                            n_fail = 1'b1;
                        end else begin
                            n_err = 1'b1;
                            it    = bad_push(it, r_mode);
                            it    = push(it, i_in_byte);
                        end
                    end else begin
                        n_held  = i_in_byte;
                        n_phase = PH_HELD;
                    end
                end
                PH_HELD: begin
                    n_phase = PH_PLAIN;
                    n_held  = 8'd0;
                    if (r_held == CHAR_CR && i_in_byte == CHAR_LF) begin
                        // soft line break: drop
                    end else if (hx_h[4] && hx_b[4]) begin
                        it = push(it, {hx_h[3:0], hx_b[3:0]});
                    end else if (is_fail) begin
                        n_fail = 1'b1;
                    end else begin
                        // Rescan both held bytes as ordinary input.
                        n_err = 1'b1;
                        it    = bad_push(it, r_mode);
                        if (r_held == CHAR_EQ) begin
                            if (i_in_last) begin
                                it = bad_push(it, r_mode);
                                it = push(it, i_in_byte);
                            end else begin
                                n_held  = i_in_byte;
                                n_phase = PH_HELD;
                            end
                        end else begin
                            it = push(it, r_held);
                            if (i_in_byte == CHAR_EQ) begin
                                if (i_in_last) begin
                                    it = bad_push(it, r_mode);
                                end else begin
                                    n_phase = PH_EQ;
                                end
                            end else begin
                                it = push(it, i_in_byte);
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_PLAIN;
                    if (i_in_byte == CHAR_EQ) begin
                        if (!i_in_last) begin
                            n_phase = PH_EQ;
                        end else if (is_fail) begin
                            n_fail = 1'b1;
                        end else begin
                            n_err = 1'b1;
                            it    = bad_push(it, r_mode);
                        end
                    end else begin
                        it = push(it, i_in_byte);
                    end
                end
            endcase
        end
        it.status = n_fail ? ST_FAIL : (n_err ? ST_ERR : ST_OK);
        if (i_in_last) begin
            n_phase = PH_PLAIN;
            n_held  = 8'd0;
            n_err   = 1'b0;
            n_fail  = 1'b0;
        end
    end

    assign o_q_item = it;
    assign o_q_push = accept && (it.cnt != 3'd0 || i_in_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_FAIL;
            r_phase <= PH_PLAIN;
            r_held  <= 8'd0;
            r_err   <= 1'b0;
            r_fail  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_data)
                    MODE_FAIL:    r_mode <= MODE_FAIL;
                    MODE_REPLACE: r_mode <= MODE_REPLACE;
                    default:      r_mode <= MODE_IGNORE;
                endcase
            end
            if (accept) begin
                r_phase <= n_phase;
                r_held  <= n_held;
                r_err   <= n_err;
                r_fail  <= n_fail;
            end
        end
    end

endmodule

### rtl/qpd_fifo.sv
// ----------------------------------------------------------------------------
// qpd_fifo
// Short item queue between the classifier and the result serializer.
// ----------------------------------------------------------------------------
module qpd_fifo import qpd_pkg::*; #(
    parameter int unsigned DEPTH = QPD_FIFO_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_wdata,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_rdata
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr + 1'b1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : PW'(r_rd + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= CW'(r_cnt + 1'b1);
            end else if (i_pop && !i_push) begin
                r_cnt <= CW'(r_cnt - 1'b1);
            end
        end
    end

endmodule

### rtl/qpd_back.sv
// ----------------------------------------------------------------------------
// qpd_back
// Walks the head item to the output register, one result per unstalled cycle.
// ----------------------------------------------------------------------------
module qpd_back import qpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_item      i_q_item,
    output logic       o_q_pop,
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid,
    output logic       o_run_last,
    output logic       o_msg_done,
    output logic [1:0] o_status
);

    logic [2:0] r_idx;
    logic       r_res_valid;
    logic [7:0] r_byte;
    logic       r_bvalid, r_run_last, r_done;
    logic [1:0] r_status;
    logic [2:0] total;
    logic       fin, load, has_data;

    assign has_data = (i_q_item.cnt != 3'd0);
    assign total    = has_data ? i_q_item.cnt : 3'd1;
    assign fin      = (r_idx == 3'(total - 3'd1));
    assign load     = !i_q_empty && (!r_res_valid || !i_res_stall);
    assign o_q_pop  = load && fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 3'd0;
            r_res_valid <= 1'b0;
        end else begin
            if (load) begin
                r_res_valid <= 1'b1;
                r_idx       <= fin ? 3'd0 : 3'(r_idx + 3'd1);
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte     <= has_data ? i_q_item.data[r_idx] : 8'd0;
            r_bvalid   <= has_data;
            r_run_last <= fin;
            r_done     <= fin && i_q_item.last;
            r_status   <= (fin && i_q_item.last) ? i_q_item.status : ST_OK;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_out_byte  = r_byte;
    assign o_out_valid = r_bvalid;
    assign o_run_last  = r_run_last;
    assign o_msg_done  = r_done;
    assign o_status    = r_status;

endmodule

### rtl/quoted_printable_decoder_top.sv
// ----------------------------------------------------------------------------
// quoted_printable_decoder_top
// Quoted-printable decoder: encoded bytes in, decoded bytes out.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_stall     i_in_byte, i_in_last
// result    out        o_res_valid / i_res_stall   o_out_byte, o_out_valid,
//                                                  o_run_last, o_msg_done, o_status
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_data (error mode)
//
// The front classifies one byte per cycle unless the queue is full; a byte
// causing one result flows through the queue and the output register at
// one item per cycle unless i_res_stall holds it. A byte causing k results
// (up to five) holds the serializer until all k enter the output register.
// Reset is synchronous, active low; it clears the escape state, the queue
// and the error mode (fail). A full queue raises o_in_stall; i_res_stall
// holds the output register and backs up into the queue.
// ----------------------------------------------------------------------------
module quoted_printable_decoder_top import qpd_pkg::*; #(
    parameter int unsigned FIFO_DEPTH = QPD_FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input items
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    // configuration write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data,
    // result items
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid,
    output logic       o_run_last,
    output logic       o_msg_done,
    output logic [1:0] o_status
);

    logic  q_full, q_empty, q_push, q_pop;
    t_item q_wdata, q_rdata;

    // Front: escape tracking and per-byte classification.
    qpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_item    (q_wdata)
    );

    // Decouple classification from result delivery.
    qpd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_rdata (q_rdata)
    );

    // Back: serialize each item into results.
    qpd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_item    (q_rdata),
        .o_q_pop     (q_pop),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_out_byte  (o_out_byte),
        .o_out_valid (o_out_valid),
        .o_run_last  (o_run_last),
        .o_msg_done  (o_msg_done),
        .o_status    (o_status)
    );

endmodule

### rtl/qpd_checker.sv
// ----------------------------------------------------------------------------
// qpd_checker
// Port-level checks of the decoder's result stream.
// ----------------------------------------------------------------------------
module qpd_checker import qpd_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_res_valid,
    input logic       i_res_stall,
    input logic [7:0] o_out_byte,
    input logic       o_out_valid,
    input logic       o_run_last,
    input logic       o_msg_done,
    input logic [1:0] o_status
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_out_byte)
            && $stable(o_msg_done) && $stable(o_status))
        else $error("stalled result changed");

    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_msg_done |-> o_run_last)
        else $error("message end not on last result of its byte");

    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_msg_done |-> o_status == ST_OK)
        else $error("status outside message end");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_out_valid |-> o_msg_done && o_out_byte == 8'd0)
        else $error("empty result not a message end");

endmodule

bind quoted_printable_decoder_top qpd_checker u_qpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_res_valid (o_res_valid),
    .i_res_stall (i_res_stall),
    .o_out_byte  (o_out_byte),
    .o_out_valid (o_out_valid),
    .o_run_last  (o_run_last),
    .o_msg_done  (o_msg_done),
    .o_status    (o_status)
);
